[src/fdbb_pkg.sv]
// Types and constants shared by the frame difference bounding box unit.
package fdbb_pkg;

  localparam int          ROW_BYTES_W     = 10;
  localparam int          POS_W           = 10;
  localparam int          SIZE_W          = 11;
  localparam logic [9:0]  ROW_BYTES_RESET = 10'd480;

  typedef struct packed {
    logic [7:0] new_byte;
    logic [7:0] old_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic              changed;
    logic [POS_W-1:0]  rect_x;
    logic [POS_W-1:0]  rect_y;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
  } out_beat_t;

endpackage

[src/frame_diff_bounding_box_unit.sv]
// Top level of the frame difference bounding box unit.
//
//   port group   direction  payload      handshake
//   in_*         input      in_beat_t    in_valid / in_stall
//   out_*        output     out_beat_t   out_valid / out_stall
//   cfg_*        input      row length   cfg_we, no wait
//
// One beat per cycle sustained; a stalled result holds the pipe only when
// the beat behind it is also marked last. Steps: an input register, one
// compare and min/max update, and a result register. A result is registered
// as its last-marked beat leaves the input register. rst_n is synchronous and
// clears counters, tracking state and valids and loads the row length 480.
module frame_diff_bounding_box_unit
  import fdbb_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 512,
  parameter int MAX_ROWS      = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  input  logic                   cfg_we,
  input  logic [ROW_BYTES_W-1:0] cfg_data
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int EW = (CW + 1 > ROW_BYTES_W + 1) ? CW + 1 : ROW_BYTES_W + 1;
  localparam logic [EW-1:0] MAX_RB_E  = EW'(MAX_ROW_BYTES);
  localparam logic [RW-1:0] ROW_LIMIT = RW'(MAX_ROWS - 1);

  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic                   s1_valid_r;
  in_beat_t               s1_beat_r;
  logic                   out_valid_r;
  out_beat_t              out_data_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          any_diff_r, any_diff_nxt;
  logic [CW-1:0] min_col_r, min_col_nxt, max_col_r, max_col_nxt;
  logic [RW-1:0] min_row_r, min_row_nxt, max_row_r, max_row_nxt;

  logic          s1_go;
  logic          differ;
  logic [CW:0]   eff_rb;
  logic [CW:0]   col_inc;
  logic [CW:0]   col_span;
  logic [RW:0]   row_span;
  out_beat_t     result;

  assign s1_go    = s1_valid_r && (!s1_beat_r.last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign differ   = s1_beat_r.new_byte != s1_beat_r.old_byte;

  always_comb begin
    if (row_bytes_r == '0) begin
      eff_rb = (CW+1)'(1);
    end else if (EW'(row_bytes_r) > MAX_RB_E) begin
      eff_rb = (CW+1)'(MAX_ROW_BYTES);
    end else begin
      eff_rb = (CW+1)'(row_bytes_r);
    end
  end

  assign col_inc = {1'b0, col_r} + (CW+1)'(1);

  always_comb begin
    any_diff_nxt = any_diff_r;
    min_col_nxt  = min_col_r;
    max_col_nxt  = max_col_r;
    min_row_nxt  = min_row_r;
    max_row_nxt  = max_row_r;
    if (differ) begin
      any_diff_nxt = 1'b1;
      if (col_r < min_col_r) min_col_nxt = col_r;
      if (col_r > max_col_r) max_col_nxt = col_r;
      if (row_r < min_row_r) min_row_nxt = row_r;
      if (row_r > max_row_r) max_row_nxt = row_r;
    end
    if (col_inc >= eff_rb) begin
      col_nxt = '0;
      row_nxt = (row_r != ROW_LIMIT) ? row_r + RW'(1) : row_r;
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  assign col_span = {1'b0, max_col_nxt} - {1'b0, min_col_nxt} + (CW+1)'(1);
  assign row_span = {1'b0, max_row_nxt} - {1'b0, min_row_nxt} + (RW+1)'(1);

  always_comb begin
    if (any_diff_nxt) begin
      result.changed     = 1'b1;
      result.rect_x      = POS_W'({min_col_nxt, 1'b0});
      result.rect_y      = POS_W'(min_row_nxt);
      result.rect_width  = SIZE_W'({col_span, 1'b0});
      result.rect_height = SIZE_W'(row_span);
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RESET;
    end else if (cfg_we) begin
      row_bytes_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_beat_r.last)) begin
      col_r      <= '0;
      row_r      <= '0;
      any_diff_r <= 1'b0;
      min_col_r  <= '1;
      max_col_r  <= '0;
      min_row_r  <= '1;
      max_row_r  <= '0;
    end else if (s1_go) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      any_diff_r <= any_diff_nxt;
      min_col_r  <= min_col_nxt;
      max_col_r  <= max_col_nxt;
      min_row_r  <= min_row_nxt;
      max_row_r  <= max_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_beat_r.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_beat_r.last) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_quiet_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.changed |->
      out_data.rect_x == '0 && out_data.rect_y == '0 &&
      out_data.rect_width == '0 && out_data.rect_height == '0)
    else $error("quiet frame result carries a nonzero rectangle");

  a_even_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.rect_width[0] && !out_data.rect_x[0])
    else $error("rectangle not aligned to byte pairs");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    any_diff_r |-> min_col_r <= max_col_r && min_row_r <= max_row_r)
    else $error("tracked box inverted");

  a_row_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_LIMIT)
    else $error("row counter beyond its limit");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_beat_r.last |=> col_r == '0 && row_r == '0 && !any_diff_r)
    else $error("tracking state not cleared after frame end");

endmodule
